### sv/rtrs_pkg.sv
// Shared types and constants for the real-to-rational stepper.
`timescale 1ns / 1ps
package rtrs_pkg;

   localparam int unsigned TRIAL_BITS_DEF = 20;

   localparam int unsigned TARGET_W   = 32;
   localparam int unsigned TOL_W      = 24;
   localparam int unsigned TRIALS_W   = 20;
   localparam int unsigned NUM_W      = 21;
   localparam int unsigned Q_SHIFT    = 24;

   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 24;

   // scaled numerator, f*den and tol*den all fit in this width
   localparam int unsigned WIDE_W  = 54;
   localparam int unsigned HALF_W  = WIDE_W / 2;
   localparam int unsigned MUL_A_W = HALF_W;
   localparam int unsigned MUL_B_W = NUM_W;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int unsigned ACC_W   = WIDE_W + MUL_B_W;

   localparam logic [WIDE_W-1:0] Q_ONE = WIDE_W'(1) << Q_SHIFT;

   localparam logic [TRIALS_W-1:0] MAX_TRIALS_RST = TRIALS_W'(240);
   localparam logic [TOL_W-1:0]    TOLERANCE_RST  = TOL_W'(34953);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRIALS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = CSR_IDX_W'(1);

   typedef struct packed {
      logic [TARGET_W-1:0] target_value;
   } rtrs_req_type;

   typedef struct packed {
      logic [NUM_W-1:0]    numerator;
      logic [NUM_W-1:0]    denominator;
      logic                converged;
      logic [TRIALS_W-1:0] trials_used;
   } rtrs_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_DECIDE,
      S_FLUSH
   } rtrs_state_type;

endpackage

### sv/rtrs_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
`timescale 1ns / 1ps
interface rtrs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/rtrs_mul.sv
// Registered 27x21 multiplier shared by all cross-multiplications.
`timescale 1ns / 1ps
module rtrs_mul import rtrs_pkg::*; (
   input  logic               clock,
   input  logic [MUL_A_W-1:0] operand_a,
   input  logic [MUL_B_W-1:0] operand_b,
   output logic [MUL_P_W-1:0] product_ff
);

   always_ff @(posedge clock) begin
      product_ff <= MUL_P_W'(operand_a) * MUL_P_W'(operand_b);
   end

endmodule

### sv/real_to_rational_stepper.sv
// Real-to-rational stepper: searches num/den close to a Q8.24 value.
// Each trial runs a check state, four passes through the shared 27x21 multiplier
// and a decide state. req is ready only while idle, so no new input is taken until
// the search ends and its result is loaded into rsp; loading waits if rsp stalls.
// Synchronous active-high reset clears control state; max_trials 240, tolerance 34953.
`timescale 1ns / 1ps
module real_to_rational_stepper import rtrs_pkg::*; #(
   parameter int unsigned TRIAL_BITS = TRIAL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rtrs_stream_if.sink           req,
   rtrs_stream_if.source         rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int unsigned CNT_W = TRIAL_BITS;

   function automatic logic [WIDE_W-1:0] abs_diff(input logic [WIDE_W-1:0] a,
                                                  input logic [WIDE_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   rtrs_state_type state_ff, state_in;

   logic [TRIALS_W-1:0] max_trials_ff;
   logic [TOL_W-1:0]    tolerance_ff;
   logic                rsp_valid_ff;
   rtrs_rsp_type        rsp_payload_ff;

   logic [TARGET_W-1:0] f_ff;
   logic [NUM_W-1:0]    num_ff, den_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                conv_ff;
   logic [WIDE_W-1:0]   n_ff, p_ff, q_ff, t_ff;
   logic [WIDE_W-1:0]   da_ff, db_ff;
   logic [ACC_W-1:0]    acc_a_ff, acc_b_ff;

   logic [CNT_W-1:0]    limit;
   logic [NUM_W-1:0]    den_plus;
   logic [WIDE_W-1:0]   err, da, db;
   logic                limit_hit, err_hit, out_free, out_load;
   logic [ACC_W-1:0]    acc_b_full;
   logic                num_step;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  product;
   logic                req_ready;

   rtrs_mul u_mul (
      .clock      (clock),
      .operand_a  (mul_a),
      .operand_b  (mul_b),
      .product_ff (product)
   );

   assign limit      = CNT_W'(max_trials_ff);
   assign den_plus   = den_ff + NUM_W'(1);
   assign err        = abs_diff(n_ff, p_ff);
   assign da         = abs_diff(n_ff + Q_ONE, p_ff);
   assign db         = abs_diff(n_ff, q_ff);
   assign limit_hit  = (cnt_ff == limit);
   assign err_hit    = (err < t_ff);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign acc_b_full = acc_b_ff + (ACC_W'(product) << HALF_W);
   // strictly closer on the num side; ties go to den
   assign num_step   = (acc_a_ff < acc_b_full);

   assign req.ready   = req_ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req.valid) state_in = S_CHECK;
         S_CHECK:  state_in = (limit_hit || err_hit) ? S_FLUSH : S_MUL0;
         S_MUL0:   state_in = S_MUL1;
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = S_MUL3;
         S_MUL3:   state_in = S_DECIDE;
         S_DECIDE: state_in = S_CHECK;
         S_FLUSH:  if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      mul_a     = da_ff[HALF_W-1:0];
      mul_b     = den_plus;
      case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_MUL0: begin
            mul_a = da_ff[HALF_W-1:0];
            mul_b = den_plus;
         end
         S_MUL1: begin
            mul_a = da_ff[WIDE_W-1:HALF_W];
            mul_b = den_plus;
         end
         S_MUL2: begin
            mul_a = db_ff[HALF_W-1:0];
            mul_b = den_ff;
         end
         S_MUL3: begin
            mul_a = db_ff[WIDE_W-1:HALF_W];
            mul_b = den_ff;
         end
         S_FLUSH: out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_trials_ff <= MAX_TRIALS_RST;
         tolerance_ff  <= TOLERANCE_RST;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_TRIALS: max_trials_ff <= csr_write_data[TRIALS_W-1:0];
               CSR_TOLERANCE:  tolerance_ff  <= csr_write_data[TOL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_payload_ff.numerator   <= num_ff;
         rsp_payload_ff.denominator <= den_ff;
         rsp_payload_ff.converged   <= conv_ff;
         rsp_payload_ff.trials_used <= TRIALS_W'(cnt_ff);
      end
   end

   // search datapath; n = num<<24, p = f*den, q = f*(den+1), t = tol*den
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               f_ff    <= req.payload.target_value;
               num_ff  <= NUM_W'(1);
               den_ff  <= NUM_W'(1);
               cnt_ff  <= '0;
               conv_ff <= 1'b0;
               n_ff    <= Q_ONE;
               p_ff    <= WIDE_W'(req.payload.target_value);
               q_ff    <= WIDE_W'(req.payload.target_value) << 1;
               t_ff    <= WIDE_W'(tolerance_ff);
            end
         end
         S_CHECK: begin
            da_ff   <= da;
            db_ff   <= db;
            conv_ff <= err_hit && !limit_hit;
         end
         S_MUL1: acc_a_ff <= ACC_W'(product);
         S_MUL2: acc_a_ff <= acc_a_ff + (ACC_W'(product) << HALF_W);
         S_MUL3: acc_b_ff <= ACC_W'(product);
         S_DECIDE: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (num_step) begin
               num_ff <= num_ff + NUM_W'(1);
               n_ff   <= n_ff + Q_ONE;
            end else begin
               den_ff <= den_plus;
               p_ff   <= p_ff + WIDE_W'(f_ff);
               q_ff   <= q_ff + WIDE_W'(f_ff);
               t_ff   <= t_ff + WIDE_W'(tolerance_ff);
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (cnt_ff <= limit))
      else $error("trial count beyond limit");

   a_step_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |->
         ((34'(num_ff) + 34'(den_ff)) == (34'(cnt_ff) + 34'd2)))
      else $error("num + den does not track the trial count");

   a_conv_early: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.converged) |->
         (33'(rsp_payload_ff.trials_used) < 33'(limit)))
      else $error("converged transaction used the whole trial budget");
`endif

endmodule
